FILE: design/cgtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cgtm_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int SAMPLE_W      = 10;
  localparam int SUM_W         = $clog2(((1 << SAMPLE_W) - 1) * HISTORY_DEPTH + 1);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH);
  localparam int DIVISOR       = HISTORY_DEPTH - 2;
  localparam int RECIP_SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W       = SUM_W + 1;
  localparam int PROD_W        = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ACCUM,
    ST_START,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

FILE: design/cgtm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cgtm_cell
  import cgtm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    shift,
  input  wire sample_t din,
  output sample_t      dout
);

  sample_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule
`default_nettype wire

FILE: design/cgtm_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module cgtm_divider
  import cgtm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire sum_t  dividend,
  output sample_t    quotient,
  output div_status_t status
);

  logic [PROD_W-1:0] product;
  logic              busy;
  logic              done;

  assign product = PROD_W'(dividend) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= product[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

FILE: design/change_gated_trimmed_mean_top.sv
// Latency: an unchanged sample gives its result in the cycle after the transaction.
// A changed sample gives its result after these steps in order: the insert state,
// one pass of the ring around the cell chain, the divider start with its reciprocal
// multiply into the quotient register, and the output register.
// Throughput: one sample at a time; unchanged samples can follow every cycle while the result
// is not stalled, and the next transaction after a changed sample is taken once its result is out.
// Reset (synchronous, active high) clears the history, the previous sample and the held average.
`timescale 1ns / 1ps
`default_nettype none
module change_gated_trimmed_mean_top
  import cgtm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  input  wire sample_t sample,
  output logic         result_valid,
  input  wire logic    result_stall,
  output logic         changed,
  output sample_t      average
);

  state_t      state;
  state_t      state_next;
  sample_t     previous_sample;
  sample_t     pending_sample;
  sample_t     held_average;
  sample_t     ring [HISTORY_DEPTH];
  sample_t     ring_in;
  sample_t     tail;
  logic        cell_shift;
  logic [CNT_W-1:0] cnt;
  sum_t        acc_sum;
  sample_t     acc_min;
  sample_t     acc_max;
  sum_t        trimmed;
  logic        div_start;
  sample_t     quotient;
  div_status_t div_status;
  logic        sample_accept;
  logic        sample_changed;

  assign sample_stall   = (state != ST_IDLE) || (result_valid && result_stall);
  assign sample_accept  = sample_valid && !sample_stall;
  assign sample_changed = (sample != previous_sample);
  assign tail           = ring[HISTORY_DEPTH-1];
  assign trimmed        = acc_sum - SUM_W'(acc_min) - SUM_W'(acc_max);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    sample_t din;
    if (i == 0) begin : g_head
      assign din = ring_in;
    end else begin : g_body
      assign din = ring[i-1];
    end
    cgtm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (cell_shift),
      .din   (din),
      .dout  (ring[i])
    );
  end

  cgtm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trimmed),
    .quotient (quotient),
    .status   (div_status)
  );

  always_comb begin
    state_next = state;
    cell_shift = 1'b0;
    div_start  = 1'b0;
    ring_in    = tail;
    case (state)
      ST_IDLE: begin
        if (sample_accept && sample_changed) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cell_shift = 1'b1;
        ring_in    = previous_sample;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cell_shift = 1'b1;
        if (cnt == CNT_W'(HISTORY_DEPTH - 1)) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      previous_sample <= '0;
      held_average    <= '0;
      result_valid    <= 1'b0;
      cnt             <= '0;
    end else begin
      state <= state_next;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (sample_accept && !sample_changed) begin
        result_valid <= 1'b1;
      end
      if (state == ST_SHIFT) begin
        previous_sample <= pending_sample;
        cnt             <= '0;
      end
      if (state == ST_ACCUM) begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_DIVIDE && div_status.done) begin
        held_average <= quotient;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      pending_sample <= sample;
      if (!sample_changed) begin
        changed <= 1'b0;
        average <= held_average;
      end
    end
    if (state == ST_ACCUM) begin
      if (cnt == '0) begin
        acc_sum <= SUM_W'(tail);
        acc_min <= tail;
        acc_max <= tail;
      end else begin
        acc_sum <= acc_sum + SUM_W'(tail);
        if (tail < acc_min) begin
          acc_min <= tail;
        end
        if (tail > acc_max) begin
          acc_max <= tail;
        end
      end
    end
    if (state == ST_DIVIDE && div_status.done) begin
      changed <= 1'b1;
      average <= quotient;
    end
  end

  a_changed_enters_shift: assert property (@(posedge clk) disable iff (rst)
    (sample_accept && sample_changed) |=> (state == ST_SHIFT))
    else $error("A changed sample did not start the ring update.");

  a_unchanged_result: assert property (@(posedge clk) disable iff (rst)
    (sample_accept && !sample_changed) |=>
      (result_valid && !changed && average == $past(held_average)))
    else $error("An unchanged sample did not return the held average.");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == ST_DIVIDE))
    else $error("Divider finished outside the divide phase.");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |-> (acc_min <= acc_max))
    else $error("Ring minimum exceeds ring maximum.");

  a_divider_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("Divider started while still busy.");

endmodule
`default_nettype wire
